// ----- design/sodc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive controller package
// Shared types, codes and constant speed commands for the drive controller.
// ----------------------------------------------------------------------------
package sodc_pkg;

    localparam int unsigned SENSOR_W = 12;
    localparam int unsigned SPEED_W  = 11;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned RANGE_N  = 5;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_ARM   = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_OTHER = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_STATIC  = 2'd0,
        MODE_CHARGER = 2'd1,
        MODE_SPINNER = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_TICK_MS     = 3'd1,
        REG_EDGE_THR    = 3'd2,
        REG_RANGE_LIMIT = 3'd3,
        REG_AUTO_ARM    = 3'd4,
        REG_REVERSE     = 3'd5,
        REG_ESCAPE_END  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [7:0]          tick_ms;
        logic [SENSOR_W-1:0] edge_threshold;
        logic [SENSOR_W-1:0] range_limit;
        logic [15:0]         self_arm_ms;
        logic [11:0]         reverse_phase_ms;
        logic [11:0]         escape_end_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [SENSOR_W-1:0] edge_front_left;
        logic [SENSOR_W-1:0] edge_front_right;
        logic [SENSOR_W-1:0] edge_rear_left;
        logic [SENSOR_W-1:0] edge_rear_right;
        logic [SENSOR_W-1:0] range_left_wide;
        logic [SENSOR_W-1:0] range_left_near;
        logic [SENSOR_W-1:0] range_center;
        logic [SENSOR_W-1:0] range_right_near;
        logic [SENSOR_W-1:0] range_right_wide;
    } item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
    } drive_t;

    localparam logic signed [SPEED_W-1:0] SPD_MAX       = 11'sd1000;
    localparam logic signed [SPEED_W-1:0] SPD_CRUISE    = 11'sd950;
    localparam logic signed [SPEED_W-1:0] SPD_ESC_BACK  = -11'sd850;
    localparam logic signed [SPEED_W-1:0] SPD_SPIN_FAST = 11'sd600;
    localparam logic signed [SPEED_W-1:0] SPD_PUSH      = 11'sd900;
    localparam logic signed [SPEED_W-1:0] SPD_SEARCH    = 11'sd450;
    localparam logic signed [SPEED_W-1:0] SPD_SPIN      = 11'sd500;

    // Turn offset per range sensor, left wide through right wide.
    localparam logic signed [SPEED_W-1:0] TURN_TAB [RANGE_N] =
        '{11'sd550, 11'sd275, 11'sd0, -11'sd275, -11'sd550};

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPEED_W:0] v
    );
        logic signed [SPEED_W:0] lim;
        lim = {SPD_MAX[SPEED_W-1], SPD_MAX};
        if (v > lim)
            return SPD_MAX;
        else if (v < -lim)
            return -SPD_MAX;
        else
            return v[SPEED_W-1:0];
    endfunction

endpackage

// ----- design/sodc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one sensor or referee word.
// ----------------------------------------------------------------------------
interface sodc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] edge_front_left;
    logic [11:0] edge_front_right;
    logic [11:0] edge_rear_left;
    logic [11:0] edge_rear_right;
    logic [11:0] range_left_wide;
    logic [11:0] range_left_near;
    logic [11:0] range_center;
    logic [11:0] range_right_near;
    logic [11:0] range_right_wide;

    modport source (
        output valid, func, edge_front_left, edge_front_right, edge_rear_left,
               edge_rear_right, range_left_wide, range_left_near, range_center,
               range_right_near, range_right_wide,
        input  ready
    );

    modport sink (
        input  valid, func, edge_front_left, edge_front_right, edge_rear_left,
               edge_rear_right, range_left_wide, range_left_near, range_center,
               range_right_near, range_right_wide,
        output ready
    );
endinterface

// ----- design/sodc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one wheel command word.
// ----------------------------------------------------------------------------
interface sodc_out_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] left_speed;
    logic signed [10:0] right_speed;
    logic               is_armed;

    modport source (
        output valid, left_speed, right_speed, is_armed,
        input  ready
    );

    modport sink (
        input  valid, left_speed, right_speed, is_armed,
        output ready
    );
endinterface

// ----- design/sumo_opponent_drive_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Opponent drive controller core
// Reactive wheel-speed controller: referee words arm or stop it, and each
// tick word with edge and range readings yields one wheel command word.
// ----------------------------------------------------------------------------
// A tick word is held in the input register, evaluated there, and then
// offered on the output from the result register.
// Throughput: one word per cycle while no untaken result blocks a tick;
// the arming, escape timer and elapsed-time state is read and rewritten
// in the single evaluation stage as each word retires.
// A tick waits in the input register only while an untaken result is held.
// Referee words update the state and produce no output word.
// Reset (rst_n low, asynchronous) disarms the controller, clears both timers
// and the escape flag, empties the pipeline and loads the default settings.
// ----------------------------------------------------------------------------
module sumo_opponent_drive_controller_core
    import sodc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sodc_in_if.sink              item,
    sodc_out_if.source           result
);

    // Settings and their register file.
    cfg_t cfg;

    sodc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register. A word waits here until the evaluation stage can
    // retire it: referee words always retire, ticks need a free result slot.
    logic  s1_valid_reg;
    item_t s1_item_reg;
    logic  s1_is_tick;
    logic  out_free;
    logic  s1_move;

    // Controller state.
    logic        armed_reg, armed_next;
    logic        referee_seen_reg, referee_seen_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        escape_active_reg, escape_active_next;
    logic [12:0] escape_ms_reg, escape_ms_next;

    // Result register.
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] left_reg, left_next;
    logic signed [SPEED_W-1:0] right_reg, right_next;
    logic                      out_armed_reg;

    assign s1_is_tick = (s1_item_reg.func == FUNC_TICK);
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_move    = s1_valid_reg && (!s1_is_tick || out_free);
    assign item.ready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_item_reg.func             <= item.func;
            s1_item_reg.edge_front_left  <= item.edge_front_left;
            s1_item_reg.edge_front_right <= item.edge_front_right;
            s1_item_reg.edge_rear_left   <= item.edge_rear_left;
            s1_item_reg.edge_rear_right  <= item.edge_rear_right;
            s1_item_reg.range_left_wide  <= item.range_left_wide;
            s1_item_reg.range_left_near  <= item.range_left_near;
            s1_item_reg.range_center     <= item.range_center;
            s1_item_reg.range_right_near <= item.range_right_near;
            s1_item_reg.range_right_wide <= item.range_right_wide;
        end
    end

    // Seek command from the five range readings, used in the charger and spare
    // modes with no edge in sight.
    logic [SENSOR_W-1:0] ranges [RANGE_N];
    drive_t              seek_drive;

    assign ranges[0] = s1_item_reg.range_left_wide;
    assign ranges[1] = s1_item_reg.range_left_near;
    assign ranges[2] = s1_item_reg.range_center;
    assign ranges[3] = s1_item_reg.range_right_near;
    assign ranges[4] = s1_item_reg.range_right_wide;

    sodc_seek u_seek (
        .range_limit (cfg.range_limit),
        .ranges      (ranges),
        .drive       (seek_drive)
    );

    // Evaluation stage: the next state and the wheel command of the word
    // in the input register.
    logic [16:0] elapsed_sum;
    logic [13:0] escape_sum;
    logic [12:0] escape_base;
    logic        armed_tick;
    logic        edge_front;
    logic        edge_rear;
    logic        escape_start;
    logic        escape_on;

    assign edge_front = (s1_item_reg.edge_front_left > cfg.edge_threshold)
                     || (s1_item_reg.edge_front_right > cfg.edge_threshold);
    assign edge_rear  = (s1_item_reg.edge_rear_left > cfg.edge_threshold)
                     || (s1_item_reg.edge_rear_right > cfg.edge_threshold);

    always_comb
    begin
        armed_next         = armed_reg;
        referee_seen_next  = referee_seen_reg;
        elapsed_next       = elapsed_reg;
        escape_active_next = escape_active_reg;
        escape_ms_next     = escape_ms_reg;
        left_next          = '0;
        right_next         = '0;

        // Elapsed time saturates at its full scale.
        elapsed_sum = {1'b0, elapsed_reg} + 17'(cfg.tick_ms);
        armed_tick  = armed_reg
                   || (!referee_seen_reg && (elapsed_next >= cfg.self_arm_ms));

        escape_start = edge_front && !escape_active_reg;
        escape_on    = escape_active_reg || escape_start;
        escape_base  = escape_start ? 13'd0 : escape_ms_reg;
        escape_sum   = {1'b0, escape_base} + 14'(cfg.tick_ms);

        if (!s1_is_tick)
        begin
            referee_seen_next = 1'b1;
            if (s1_item_reg.func == FUNC_ARM)
            begin
                armed_next         = 1'b1;
                escape_active_next = 1'b0;
            end
            else if (s1_item_reg.func == FUNC_STOP)
            begin
                armed_next = 1'b0;
            end
        end
        else
        begin
            elapsed_next = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
            armed_tick   = armed_reg
                        || (!referee_seen_reg && (elapsed_next >= cfg.self_arm_ms));
            armed_next   = armed_tick;

            if (armed_tick && (cfg.mode != MODE_STATIC))
            begin
                if (cfg.mode == MODE_SPINNER)
                begin
                    if (edge_front || edge_rear)
                    begin
                        left_next  = -SPD_SPIN_FAST;
                        right_next = -SPD_SPIN_FAST;
                    end
                    else
                    begin
                        left_next  = -SPD_SPIN;
                        right_next = SPD_SPIN;
                    end
                end
                else if (escape_on)
                begin
                    // Escape: straight reverse, then turn, ending once the
                    // timer passes the end mark.
                    escape_ms_next = escape_sum[13] ? 13'h1FFF : escape_sum[12:0];
                    if (escape_ms_next < {1'b0, cfg.reverse_phase_ms})
                    begin
                        left_next  = SPD_ESC_BACK;
                        right_next = SPD_ESC_BACK;
                    end
                    else
                    begin
                        left_next  = -SPD_SPIN_FAST;
                        right_next = SPD_SPIN_FAST;
                    end
                    escape_active_next =
                        !(escape_ms_next > {1'b0, cfg.escape_end_ms});
                end
                else if (edge_rear)
                begin
                    left_next  = SPD_PUSH;
                    right_next = SPD_PUSH;
                end
                else
                begin
                    left_next  = seek_drive.left;
                    right_next = seek_drive.right;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg         <= 1'b0;
            referee_seen_reg  <= 1'b0;
            elapsed_reg       <= '0;
            escape_active_reg <= 1'b0;
            escape_ms_reg     <= '0;
        end
        else if (s1_move)
        begin
            armed_reg         <= armed_next;
            referee_seen_reg  <= referee_seen_next;
            elapsed_reg       <= elapsed_next;
            escape_active_reg <= escape_active_next;
            escape_ms_reg     <= escape_ms_next;
        end
    end

    // Result register: loaded by a retiring tick, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move && s1_is_tick)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_is_tick)
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            out_armed_reg <= armed_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_speed  = left_reg;
    assign result.right_speed = right_reg;
    assign result.is_armed    = out_armed_reg;

    // Commands stay within full speed in both directions.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (left_reg <= SPD_MAX) && (left_reg >= -SPD_MAX)
                       && (right_reg <= SPD_MAX) && (right_reg >= -SPD_MAX))
        else $error("wheel command out of range");

    // A disarmed controller commands standstill.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_armed_reg) |-> (left_reg == '0) && (right_reg == '0))
        else $error("disarmed controller commands motion");

    // Elapsed time never runs backwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg >= $past(elapsed_reg))
        else $error("elapsed time decreased");

    // A referee word never loads the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !s1_is_tick && !out_valid_reg) |=> !out_valid_reg)
        else $error("referee word produced a result");

endmodule

// ----- design/sodc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file holding mode, timing and threshold settings.
// ----------------------------------------------------------------------------
module sodc_cfg
    import sodc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= MODE_CHARGER;
            cfg_reg.tick_ms          <= 8'd32;
            cfg_reg.edge_threshold   <= 12'd400;
            cfg_reg.range_limit      <= 12'd1190;
            cfg_reg.self_arm_ms      <= 16'd5000;
            cfg_reg.reverse_phase_ms <= 12'd300;
            cfg_reg.escape_end_ms    <= 12'd700;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:        cfg_reg.mode             <= cfg_data[1:0];
                REG_TICK_MS:     cfg_reg.tick_ms          <= cfg_data[7:0];
                REG_EDGE_THR:    cfg_reg.edge_threshold   <= cfg_data[11:0];
                REG_RANGE_LIMIT: cfg_reg.range_limit      <= cfg_data[11:0];
                REG_AUTO_ARM:    cfg_reg.self_arm_ms      <= cfg_data[15:0];
                REG_REVERSE:     cfg_reg.reverse_phase_ms <= cfg_data[11:0];
                REG_ESCAPE_END:  cfg_reg.escape_end_ms    <= cfg_data[11:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/sodc_seek.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target seek
// Picks the nearest valid range sensor and turns it into a steering command.
// ----------------------------------------------------------------------------
module sodc_seek
    import sodc_pkg::*;
(
    input  logic [SENSOR_W-1:0] range_limit,
    input  logic [SENSOR_W-1:0] ranges [RANGE_N],
    output drive_t              drive
);

    always_comb
    begin
        logic [SENSOR_W-1:0]       best;
        logic                      hit;
        logic [2:0]                idx;
        logic signed [SPEED_W-1:0] turn;

        best = range_limit;
        hit  = 1'b0;
        idx  = '0;
        // Strict compare keeps the first sensor on a tie.
        for (int i = 0; i < RANGE_N; i++)
        begin
            if (ranges[i] < best)
            begin
                best = ranges[i];
                hit  = 1'b1;
                idx  = 3'(i);
            end
        end

        turn = TURN_TAB[idx];
        if (hit)
        begin
            drive.left  = clamp_speed({SPD_CRUISE[SPEED_W-1], SPD_CRUISE}
                                      - {turn[SPEED_W-1], turn});
            drive.right = clamp_speed({SPD_CRUISE[SPEED_W-1], SPD_CRUISE}
                                      + {turn[SPEED_W-1], turn});
        end
        else
        begin
            drive.left  = -SPD_SEARCH;
            drive.right = SPD_SEARCH;
        end
    end

endmodule
